[rtl/core/sitod_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; used by sitod_bcd and signed_int_to_decimal_ascii.

package sitod_pkg;

    // ASCII codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // Double-dabble correction: a digit of five or more gets three added before the shift
    localparam logic [3:0] DIG_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIG_ADJ     = 4'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Commands from the sequencer to the BCD converter
    typedef struct packed {
        logic load;        // start a new conversion
        logic next_digit;  // drop the top digit, bring the next one up
    } t_bcd_ctrl;

endpackage

[rtl/core/sitod_bcd.sv]
// Bit-serial binary to BCD converter (shift and add three), one magnitude bit per cycle.
// Depends on sitod_pkg for the command struct and correction constants.

module sitod_bcd #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sitod_pkg::t_bcd_ctrl  i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    output logic                  o_busy,
    output logic [3:0]            o_digit
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int BW = NDIG * 4;

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic [BW-1:0]          adj;

    // Per-digit correction, each digit on its own
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= sitod_pkg::DIG_ADJ_MIN) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + sitod_pkg::DIG_ADJ;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // Load, convert one bit, or step the digits out
    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        priority if (i_ctrl.load) begin
            n_mag  = i_mag;
            n_bcd  = '0;
            n_cnt  = CW'(VALUE_WIDTH - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BW-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end else if (i_ctrl.next_digit) begin
            n_bcd = {r_bcd[BW-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_busy  = r_busy;
    assign o_digit = r_bcd[BW-1 -: 4];

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed integer in, decimal ASCII characters out, one per request.
// Depends on sitod_pkg and sitod_bcd.
//
// Each accepted request carries a two's complement integer in the low VALUE_WIDTH bits
// of the input data; the block sends back its decimal text, most significant character
// first, with tlast on the final character. Negative numbers get a leading '-', zero
// gives a single '0' and the most negative value prints correctly. One number is handled
// at a time: the magnitude goes through a bit-serial shift-and-add-three converter, one
// bit per cycle, then the decimal positions are scanned one per cycle, leading zeros
// skipped; a shown digit waits while the output side stalls. NDIG is the number of
// decimal positions of VALUE_WIDTH bits. The last character sits in the output
// register while the next number is accepted.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32,
    localparam int IN_RAW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32,
    localparam int IN_BITS = ((IN_RAW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [IN_BITS-1:0] i_s_axis_tdata,   // [VALUE_WIDTH-1:0] value, rest unused
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [7:0] character
    output logic               o_m_axis_tlast    // last_char
);

    localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int DCW  = $clog2(NDIG + 1);

    sitod_pkg::t_state    r_state, n_state;
    logic                 r_neg, n_neg;
    logic [DCW-1:0]       r_dcnt, n_dcnt;
    logic                 r_seen, n_seen;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    sitod_pkg::t_bcd_ctrl bcd_ctrl;
    logic                 bcd_busy;
    logic [3:0]           bcd_digit;
    logic [VALUE_WIDTH-1:0] in_raw;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                 in_accept;
    logic                 out_free;
    logic                 dig_last;
    logic                 dig_show;

    // Magnitude of the incoming value, most negative taken as unsigned
    assign in_raw    = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_mag    = in_raw[VALUE_WIDTH-1] ? (~in_raw + VALUE_WIDTH'(1)) : in_raw;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign dig_last  = (r_dcnt == DCW'(1));
    assign dig_show  = r_seen || (bcd_digit != 4'd0) || dig_last;

    sitod_bcd #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (bcd_ctrl),
        .i_mag   (in_mag),
        .o_busy  (bcd_busy),
        .o_digit (bcd_digit)
    );

    // Sequencer: next state, converter commands and output register
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_dcnt      = r_dcnt;
        n_seen      = r_seen;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        bcd_ctrl    = '0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            sitod_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    bcd_ctrl.load = 1'b1;
                    n_neg         = in_raw[VALUE_WIDTH-1];
                    n_state       = sitod_pkg::ST_CONV;
                end
            end
            sitod_pkg::ST_CONV: begin
                if (!bcd_busy) begin
                    n_dcnt  = DCW'(NDIG);
                    n_seen  = 1'b0;
                    n_state = r_neg ? sitod_pkg::ST_SIGN : sitod_pkg::ST_EMIT;
                end
            end
            sitod_pkg::ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sitod_pkg::CHR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = sitod_pkg::ST_EMIT;
                end
            end
            sitod_pkg::ST_EMIT: begin
                if (!dig_show) begin
                    // leading zero: skip it
                    bcd_ctrl.next_digit = 1'b1;
                    n_dcnt              = r_dcnt - DCW'(1);
                end else if (out_free) begin
                    bcd_ctrl.next_digit = 1'b1;
                    n_dcnt              = r_dcnt - DCW'(1);
                    n_seen              = 1'b1;
                    n_out_valid         = 1'b1;
                    n_out_char          = sitod_pkg::CHR_ZERO + {4'd0, bcd_digit};
                    n_out_last          = dig_last;
                    if (dig_last) begin
                        n_state = sitod_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sitod_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sitod_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_neg      <= n_neg;
        r_dcnt     <= n_dcnt;
        r_seen     <= n_seen;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == sitod_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // An accepted request always starts the converter
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == sitod_pkg::ST_CONV) && bcd_busy)
        else $error("conversion did not start after request");

    // Only a minus sign or a decimal digit is ever presented
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata == sitod_pkg::CHR_MINUS) ||
            ((o_m_axis_tdata >= sitod_pkg::CHR_ZERO) &&
             (o_m_axis_tdata <= sitod_pkg::CHR_NINE)))
        else $error("illegal character on output");

    // The sign never ends the text
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata == sitod_pkg::CHR_MINUS)) |-> !o_m_axis_tlast)
        else $error("minus sign flagged as last character");

    // Digit scan never runs past the last position
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitod_pkg::ST_EMIT) |-> (r_dcnt != '0))
        else $error("digit scan ran out of positions");

endmodule

[tb/signed_int_to_decimal_ascii_test.sv]
// Self-checking testbench for signed_int_to_decimal_ascii: integers go in, decimal text comes out.
// Depends on sitod_pkg for the ASCII constants and on the block itself; no other files.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;

    // One character of decimal text as the block should send it
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // One integer waiting to be offered, with the idle cycles to leave after it
    typedef struct {
        logic [31:0] value;
        int          gap;
    } t_pending_value;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_data;
    logic        m_last;

    t_pending_value pending_values_q[$];
    t_text_char     awaited_text_q[$];

    int send_gap = 0;
    int rx_gap = 0;
    int values_accepted = 0;
    int chars_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int error_count = 0;

    signed_int_to_decimal_ascii i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [31:0] value
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] character
        .o_m_axis_tlast  (m_last)    // last_char
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Work out the decimal text of one accepted integer and queue it up
    function automatic void queue_decimal_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        t_text_char  c;
        // two's complement magnitude; the most negative value stays 2^31 as unsigned
        mag = raw[31] ? (~raw + 32'd1) : raw;
        do begin
            digits.push_front(sitod_pkg::CHR_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (raw[31]) begin
            digits.push_front(sitod_pkg::CHR_MINUS);
        end
        foreach (digits[k]) begin
            c.ch   = digits[k];
            c.last = (k == digits.size() - 1);
            awaited_text_q.push_back(c);
        end
    endfunction

    // Idle length: mode 0 none, otherwise mostly short with the odd long one
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(10, 60);
        end
    endfunction

    // Random integer, either sign: a quarter fully random, the rest below a random power of ten
    function automatic logic [31:0] random_value();
        longint upper;
        longint mag;
        int     ndig;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        ndig  = $urandom_range(1, 10);
        upper = 1;
        for (int k = 0; k < ndig; k++) begin
            upper = upper * 10;
        end
        upper = (upper > 64'sd2147483648) ? 64'sd2147483648 : upper;
        mag   = {$urandom, $urandom} % upper;
        return ($urandom_range(0, 1) == 1) ? 32'(-mag) : 32'(mag);
    endfunction

    // Request side: offer queued integers, predict the text on every accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                queue_decimal_text(s_data);
                values_accepted <= values_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_values_q.size() != 0) begin
                    s_data   <= pending_values_q[0].value;
                    send_gap <= pending_values_q[0].gap;
                    s_valid  <= 1'b1;
                    void'(pending_values_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once, with the sender still busy, so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && values_accepted >= 100) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
    end

    // Result side: random back-pressure, compare each character with the oldest expectation
    always @(posedge i_clk) begin : rx_side
        int         next_gap;
        t_text_char want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            next_gap = (rx_gap > 0) ? rx_gap - 1 : 0;
            if (m_ready && m_valid) begin
                chars_seen <= chars_seen + 1;
                if (awaited_text_q.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, m_data, m_last);
                    error_count++;
                end else begin
                    want = awaited_text_q.pop_front();
                    if (m_data !== want.ch) begin
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.ch, m_data);
                        error_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: tlast mismatch: expected %b, actual %b",
                                 $time, want.last, m_last);
                        error_count++;
                    end
                end
                // stall pattern cycles through none, mixed, mixed
                next_gap = pick_gap((chars_seen / 200) % 3);
            end
            rx_gap  <= next_gap;
            m_ready <= (next_gap == 0) && (hold_left == 0);
        end
    end

    // Stimulus and end of run
    initial begin
        logic [31:0] directed[$];
        t_pending_value item;
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999999999,
                     32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'd123456789,
                     -32'sd5, 32'd7, 32'hAAAA_AAAA, 32'h5555_5555, 32'd2000000000};
        foreach (directed[k]) begin
            item.value = directed[k];
            item.gap   = pick_gap(1);
            pending_values_q.push_back(item);
        end
        for (int k = 0; k < 200; k++) begin
            item.value = random_value();
            // a burst with no gaps around the hold-off keeps the input side busy
            item.gap   = (k >= 70 && k < 130) ? 0 : pick_gap(k % 3);
            pending_values_q.push_back(item);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values_q.size() != 0 || s_valid) @(posedge i_clk);
        while (awaited_text_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS signed_int_to_decimal_ascii");
        end else begin
            $display("FAIL signed_int_to_decimal_ascii");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("FAIL signed_int_to_decimal_ascii");
        $finish;
    end

endmodule
